// ===== rtl/core/hsta_pkg.sv =====
// Shared types and constants for the handle slot table allocator.
package hsta_pkg;

	localparam int SLOTS_DEF        = 64;
	localparam int HANDLE_BITS_DEF  = 24;
	localparam int CONTEXT_BITS_DEF = 16;

	localparam int NODE_SHIFT = 24;

	localparam logic [1:0] CMD_REGISTER = 2'd0;
	localparam logic [1:0] CMD_RETIRE   = 2'd1;
	localparam logic [1:0] CMD_LOOKUP   = 2'd2;

	localparam logic [1:0] ST_OK        = 2'd0;
	localparam logic [1:0] ST_NOT_FOUND = 2'd1;
	localparam logic [1:0] ST_FULL      = 2'd2;

	typedef enum logic [2:0] {
		S_CLEAR,
		S_IDLE,
		S_PROBE_RD,
		S_PROBE_CHK,
		S_LOOK_RD,
		S_LOOK_CHK,
		S_RESP
	} state_t;

	typedef struct packed {
		logic load_req;
		logic clr_wr;
		logic rd_probe;
		logic rd_lookup;
		logic probe_adv;
		logic alloc_wr;
		logic set_full;
		logic set_bad;
		logic lookup_done;
		logic out_load;
	} ctl_t;

	typedef struct packed {
		logic clr_last;
		logic slot_free;
		logic probe_last;
		logic out_free;
	} sts_t;

endpackage

// ===== rtl/core/hsta_ifs.sv =====
// Request and response channel interfaces of the handle slot table allocator.
interface hsta_req_if;
	logic        valid;
	logic        ready;
	logic [1:0]  cmd;
	logic [31:0] handle_in;
	logic [15:0] context_in;

	modport source(output valid, output cmd, output handle_in, output context_in, input ready);
	modport sink(input valid, input cmd, input handle_in, input context_in, output ready);
endinterface

interface hsta_rsp_if;
	logic        valid;
	logic        ready;
	logic [1:0]  status;
	logic [31:0] handle_out;
	logic [15:0] context_out;

	modport source(output valid, output status, output handle_out, output context_out,
		input ready);
	modport sink(input valid, input status, input handle_out, input context_out,
		output ready);
endinterface

// ===== rtl/core/hsta_ctrl.sv =====
// Controller state machine of the handle slot table allocator.
module hsta_ctrl (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              req_valid,
	input  logic [1:0]        req_cmd,
	input  hsta_pkg::sts_t    sts,
	output logic              req_ready,
	output hsta_pkg::ctl_t    ctl
);

	hsta_pkg::state_t state_q, state_d;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= hsta_pkg::S_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	always_comb begin
		state_d   = state_q;
		req_ready = 1'b0;
		ctl       = '0;
		case (state_q)
			hsta_pkg::S_CLEAR: begin
				ctl.clr_wr = 1'b1;
				if (sts.clr_last) begin
					state_d = hsta_pkg::S_IDLE;
				end
			end
			hsta_pkg::S_IDLE: begin
				req_ready = 1'b1;
				if (req_valid) begin
					ctl.load_req = 1'b1;
					case (req_cmd)
						hsta_pkg::CMD_REGISTER: state_d = hsta_pkg::S_PROBE_RD;
						hsta_pkg::CMD_RETIRE,
						hsta_pkg::CMD_LOOKUP:   state_d = hsta_pkg::S_LOOK_RD;
						default: begin
							ctl.set_bad = 1'b1;
							state_d     = hsta_pkg::S_RESP;
						end
					endcase
				end
			end
			hsta_pkg::S_PROBE_RD: begin
				ctl.rd_probe = 1'b1;
				state_d      = hsta_pkg::S_PROBE_CHK;
			end
			hsta_pkg::S_PROBE_CHK: begin
				if (sts.slot_free) begin
					ctl.alloc_wr = 1'b1;
					state_d      = hsta_pkg::S_RESP;
				end else if (sts.probe_last) begin
					ctl.set_full = 1'b1;
					state_d      = hsta_pkg::S_RESP;
				end else begin
					ctl.probe_adv = 1'b1;
					state_d       = hsta_pkg::S_PROBE_RD;
				end
			end
			hsta_pkg::S_LOOK_RD: begin
				ctl.rd_lookup = 1'b1;
				state_d       = hsta_pkg::S_LOOK_CHK;
			end
			hsta_pkg::S_LOOK_CHK: begin
				ctl.lookup_done = 1'b1;
				state_d         = hsta_pkg::S_RESP;
			end
			hsta_pkg::S_RESP: begin
				if (sts.out_free) begin
					ctl.out_load = 1'b1;
					state_d      = hsta_pkg::S_IDLE;
				end
			end
			default: begin
				state_d = hsta_pkg::S_IDLE;
			end
		endcase
	end

endmodule

// ===== rtl/core/hsta_dp.sv =====
// Datapath of the handle slot table allocator: slot memory, probe counters, result registers.
module hsta_dp #(
	parameter int SLOTS        = hsta_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS  = hsta_pkg::HANDLE_BITS_DEF,
	parameter int CONTEXT_BITS = hsta_pkg::CONTEXT_BITS_DEF
) (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              cfg_we,
	input  logic [7:0]        cfg_wdata,
	input  logic [1:0]        req_cmd,
	input  logic [31:0]       req_handle,
	input  logic [15:0]       req_context,
	input  logic              rsp_ready,
	output logic              rsp_valid,
	output logic [1:0]        rsp_status,
	output logic [31:0]       rsp_handle,
	output logic [15:0]       rsp_context,
	input  hsta_pkg::ctl_t    ctl,
	output hsta_pkg::sts_t    sts
);

	localparam int SLOT_BITS = $clog2(SLOTS);
	localparam int EW        = 1 + HANDLE_BITS + CONTEXT_BITS;
	localparam logic [HANDLE_BITS-1:0] HMASK = '1;
	localparam logic [SLOT_BITS-1:0]   LAST_SLOT = SLOT_BITS'(SLOTS - 1);

	logic [EW-1:0]           mem_q [SLOTS];
	logic [EW-1:0]           rd_s1;
	logic                    mem_we;
	logic [SLOT_BITS-1:0]    mem_waddr;
	logic [EW-1:0]           mem_wdata;
	logic                    rd_en;
	logic [SLOT_BITS-1:0]    rd_addr;

	logic [7:0]              node_id_q;
	logic [1:0]              req_cmd_q;
	logic [31:0]             req_handle_q;
	logic [CONTEXT_BITS-1:0] req_ctx_q;
	logic [HANDLE_BITS-1:0]  next_idx_q;
	logic [HANDLE_BITS-1:0]  probe_h_q;
	logic [HANDLE_BITS-1:0]  probe_h_inc;
	logic [SLOT_BITS-1:0]    probe_cnt_q;
	logic [SLOT_BITS-1:0]    clr_cnt_q;
	logic [SLOT_BITS-1:0]    probe_slot;
	logic [SLOT_BITS-1:0]    look_slot;

	logic                    rd_vld;
	logic [HANDLE_BITS-1:0]  rd_handle;
	logic [CONTEXT_BITS-1:0] rd_ctx;
	logic [31:0]             node_bits;
	logic                    match;

	logic [1:0]              res_status_q;
	logic [31:0]             res_handle_q;
	logic [15:0]             res_ctx_q;
	logic                    rsp_valid_q;
	logic [1:0]              rsp_status_q;
	logic [31:0]             rsp_handle_q;
	logic [15:0]             rsp_ctx_q;

	assign node_bits   = {node_id_q, 24'd0};
	assign probe_slot  = SLOT_BITS'(probe_h_q);
	assign look_slot   = SLOT_BITS'(req_handle_q[HANDLE_BITS-1:0]);
	assign probe_h_inc = (probe_h_q == HMASK) ? HANDLE_BITS'(1) : probe_h_q + 1'b1;

	assign rd_vld    = rd_s1[EW-1];
	assign rd_handle = rd_s1[EW-2 -: HANDLE_BITS];
	assign rd_ctx    = rd_s1[CONTEXT_BITS-1:0];
	assign match     = rd_vld && (req_handle_q == (node_bits | 32'(rd_handle)));

	// slot memory write port
	always_comb begin
		mem_we    = 1'b0;
		mem_waddr = clr_cnt_q;
		mem_wdata = '0;
		if (ctl.clr_wr) begin
			mem_we = 1'b1;
		end else if (ctl.alloc_wr) begin
			mem_we    = 1'b1;
			mem_waddr = probe_slot;
			mem_wdata = {1'b1, probe_h_q, req_ctx_q};
		end else if (ctl.lookup_done && match && req_cmd_q == hsta_pkg::CMD_RETIRE) begin
			mem_we    = 1'b1;
			mem_waddr = look_slot;
		end
	end

	assign rd_en   = ctl.rd_probe | ctl.rd_lookup;
	assign rd_addr = ctl.rd_probe ? probe_slot : look_slot;

	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem_q[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_s1 <= mem_q[rd_addr];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			node_id_q   <= '0;
			next_idx_q  <= HANDLE_BITS'(1);
			clr_cnt_q   <= '0;
			rsp_valid_q <= 1'b0;
		end else begin
			if (cfg_we) begin
				node_id_q <= cfg_wdata;
			end
			if (ctl.clr_wr) begin
				clr_cnt_q <= clr_cnt_q + 1'b1;
			end
			if (ctl.alloc_wr) begin
				next_idx_q <= probe_h_inc;
			end
			if (ctl.out_load) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_ready) begin
				rsp_valid_q <= 1'b0;
			end
		end
	end

	always_ff @(posedge clk) begin
		if (ctl.load_req) begin
			req_cmd_q    <= req_cmd;
			req_handle_q <= req_handle;
			req_ctx_q    <= CONTEXT_BITS'(req_context);
			probe_h_q    <= next_idx_q;
			probe_cnt_q  <= '0;
		end else if (ctl.probe_adv) begin
			probe_h_q   <= probe_h_inc;
			probe_cnt_q <= probe_cnt_q + 1'b1;
		end

		if (ctl.set_bad) begin
			res_status_q <= hsta_pkg::ST_NOT_FOUND;
			res_handle_q <= '0;
			res_ctx_q    <= '0;
		end else if (ctl.set_full) begin
			res_status_q <= hsta_pkg::ST_FULL;
			res_handle_q <= '0;
			res_ctx_q    <= '0;
		end else if (ctl.alloc_wr) begin
			res_status_q <= hsta_pkg::ST_OK;
			res_handle_q <= node_bits | 32'(probe_h_q);
			res_ctx_q    <= '0;
		end else if (ctl.lookup_done) begin
			res_status_q <= match ? hsta_pkg::ST_OK : hsta_pkg::ST_NOT_FOUND;
			res_handle_q <= '0;
			res_ctx_q    <= match ? 16'(rd_ctx) : 16'd0;
		end

		if (ctl.out_load) begin
			rsp_status_q <= res_status_q;
			rsp_handle_q <= res_handle_q;
			rsp_ctx_q    <= res_ctx_q;
		end
	end

	assign sts.clr_last   = (clr_cnt_q == LAST_SLOT);
	assign sts.slot_free  = !rd_vld;
	assign sts.probe_last = (probe_cnt_q == LAST_SLOT);
	assign sts.out_free   = !rsp_valid_q || rsp_ready;

	assign rsp_valid   = rsp_valid_q;
	assign rsp_status  = rsp_status_q;
	assign rsp_handle  = rsp_handle_q;
	assign rsp_context = rsp_ctx_q;

endmodule

// ===== rtl/core/handle_slot_table_allocator.sv =====
// Top level of the handle slot table allocator.
// Lookup, retire: S_LOOK_RD reads the slot, S_LOOK_CHK compares, S_RESP loads the response.
// Register: one read (S_PROBE_RD) and one check (S_PROBE_CHK) per probed slot, up to SLOTS.
// Unused command: straight to S_RESP. The next transfer is taken only back in S_IDLE.
// After reset a clear pass zeroes the valid bits with req.ready low; node_id is 0.
module handle_slot_table_allocator #(
	parameter int SLOTS        = hsta_pkg::SLOTS_DEF,
	parameter int HANDLE_BITS  = hsta_pkg::HANDLE_BITS_DEF,
	parameter int CONTEXT_BITS = hsta_pkg::CONTEXT_BITS_DEF
) (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        cfg_we,
	input  logic [7:0]  cfg_wdata,
	hsta_req_if.sink    req,
	hsta_rsp_if.source  rsp
);

	hsta_pkg::ctl_t ctl;
	hsta_pkg::sts_t sts;
	logic           req_ready;

	assign req.ready = req_ready;

	hsta_ctrl u_ctrl (
		.clk       (clk),
		.arst_n    (arst_n),
		.req_valid (req.valid),
		.req_cmd   (req.cmd),
		.sts       (sts),
		.req_ready (req_ready),
		.ctl       (ctl)
	);

	hsta_dp #(
		.SLOTS        (SLOTS),
		.HANDLE_BITS  (HANDLE_BITS),
		.CONTEXT_BITS (CONTEXT_BITS)
	) u_dp (
		.clk         (clk),
		.arst_n      (arst_n),
		.cfg_we      (cfg_we),
		.cfg_wdata   (cfg_wdata),
		.req_cmd     (req.cmd),
		.req_handle  (req.handle_in),
		.req_context (req.context_in),
		.rsp_ready   (rsp.ready),
		.rsp_valid   (rsp.valid),
		.rsp_status  (rsp.status),
		.rsp_handle  (rsp.handle_out),
		.rsp_context (rsp.context_out),
		.ctl         (ctl),
		.sts         (sts)
	);

endmodule

// ===== dv/handle_slot_table_allocator_tb.sv =====
// Self-checking handle slot table allocator bench: directed and random traffic vs a table model.
module handle_slot_table_allocator_tb;

	localparam int SLOTS = hsta_pkg::SLOTS_DEF;
	localparam int unsigned HMASK = (1 << hsta_pkg::HANDLE_BITS_DEF) - 1;
	localparam logic [1:0] CMD_UNUSED = 2'd3;
	localparam int PHASES = 5;

	typedef struct packed {
		logic [1:0]  cmd;
		logic [31:0] handle;
		logic [15:0] ctx;
	} table_cmd_t;

	typedef struct packed {
		logic [1:0]  status;
		logic [31:0] handle;
		logic [15:0] ctx;
	} table_reply_t;

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [7:0] cfg_wdata;

	hsta_req_if req_ch();
	hsta_rsp_if rsp_ch();

	handle_slot_table_allocator DUT (
		.clk      (clk),
		.arst_n   (arst_n),
		.cfg_we   (cfg_we),
		.cfg_wdata(cfg_wdata),
		.req      (req_ch),
		.rsp      (rsp_ch)
	);

	// table model
	bit          tbl_valid   [SLOTS];
	bit          tbl_written [SLOTS];
	logic [23:0] tbl_handle  [SLOTS];
	logic [15:0] tbl_ctx     [SLOTS];
	int unsigned next_local = 1;
	logic [7:0]  node_cur = 8'h00;

	table_cmd_t   cmd_backlog[$];
	table_reply_t owed_replies[$];
	int issued, taken, err_count;
	int n_alloc, n_full, n_hit, n_miss, n_unused;
	int idle_pct, stall_pct;
	bit req_fire;

	int          ph_items [PHASES] = '{100, 90, 80, 90, 90};
	int          ph_reg   [PHASES] = '{85, 45, 20, 45, 70};
	int          ph_ret   [PHASES] = '{5, 25, 55, 25, 10};
	int          ph_idle  [PHASES] = '{0, 68, 0, 36, 36};
	int          ph_stall [PHASES] = '{0, 0, 68, 36, 36};
	logic [7:0]  ph_node  [PHASES] = '{8'hFF, 8'h00, 8'h5A, 8'h80, 8'h01};

	initial begin
		clk = 1'b0;
		forever #2 clk = ~clk;
	end

	function automatic logic [31:0] full_handle(logic [23:0] local_h);
		return {node_cur, local_h};
	endfunction

	function automatic table_reply_t serve_command(table_cmd_t c);
		table_reply_t r;
		int unsigned probe;
		int s;
		int i;
		r.status = hsta_pkg::ST_NOT_FOUND;
		r.handle = '0;
		r.ctx = '0;
		case (c.cmd)
			hsta_pkg::CMD_REGISTER: begin
				r.status = hsta_pkg::ST_FULL;
				probe = next_local;
				for (i = 0; i < SLOTS; i++) begin
					if (probe > HMASK)
						probe = 1;
					s = probe % SLOTS;
					if (!tbl_valid[s]) begin
						tbl_valid[s] = 1'b1;
						tbl_written[s] = 1'b1;
						tbl_handle[s] = probe[23:0];
						tbl_ctx[s] = c.ctx;
						next_local = (probe + 1 > HMASK) ? 1 : probe + 1;
						r.status = hsta_pkg::ST_OK;
						r.handle = full_handle(probe[23:0]);
						break;
					end
					probe++;
				end
				if (r.status == hsta_pkg::ST_OK)
					n_alloc++;
				else
					n_full++;
			end
			hsta_pkg::CMD_RETIRE, hsta_pkg::CMD_LOOKUP: begin
				s = int'(c.handle[5:0]);
				if (tbl_valid[s] && full_handle(tbl_handle[s]) == c.handle) begin
					r.status = hsta_pkg::ST_OK;
					r.ctx = tbl_ctx[s];
					if (c.cmd == hsta_pkg::CMD_RETIRE)
						tbl_valid[s] = 1'b0;
					n_hit++;
				end else begin
					n_miss++;
				end
			end
			default: n_unused++;
		endcase
		return r;
	endfunction

	// retire/lookup only ever target slots that have been written once
	function automatic table_cmd_t make_item(int reg_pct, int ret_pct);
		table_cmd_t it;
		int live[$];
		int seen[$];
		int roll;
		int s;
		foreach (tbl_valid[i]) begin
			if (tbl_valid[i])
				live.push_back(i);
			if (tbl_written[i])
				seen.push_back(i);
		end
		roll = $urandom_range(99);
		it.handle = $urandom;
		it.ctx = ($urandom_range(7) == 0) ? {16{roll[0]}} : 16'($urandom);
		if (roll < 4) begin
			it.cmd = CMD_UNUSED;
		end else if (roll < 4 + reg_pct || seen.size() == 0) begin
			it.cmd = hsta_pkg::CMD_REGISTER;
		end else begin
			it.cmd = (roll < 4 + reg_pct + ret_pct) ? hsta_pkg::CMD_RETIRE
				: hsta_pkg::CMD_LOOKUP;
			if (live.size() != 0 && $urandom_range(99) < 70) begin
				s = live[$urandom_range(live.size() - 1)];
				it.handle = full_handle(tbl_handle[s]);
			end else begin
				s = seen[$urandom_range(seen.size() - 1)];
				case ($urandom_range(3))
					0: it.handle[5:0] = 6'(s);
					1: it.handle = full_handle(tbl_handle[s]);
					2: it.handle = {node_cur ^ 8'($urandom_range(255, 1)), tbl_handle[s]};
					default: it.handle = full_handle(tbl_handle[s] ^
						{18'($urandom_range(18'h3FFFF, 1)), 6'd0});
				endcase
			end
		end
		return it;
	endfunction

	task automatic push_cmd(logic [1:0] cmd, logic [31:0] handle, logic [15:0] ctx);
		table_cmd_t it;
		it.cmd = cmd;
		it.handle = handle;
		it.ctx = ctx;
		cmd_backlog.push_back(it);
	endtask

	task automatic write_node(logic [7:0] v);
		@(negedge clk);
		cfg_we <= 1'b1;
		cfg_wdata <= v;
		@(negedge clk);
		cfg_we <= 1'b0;
	endtask

	task automatic wait_quiet();
		while (cmd_backlog.size() != 0 || issued != taken || owed_replies.size() != 0)
			@(negedge clk);
		repeat (8) @(negedge clk);
	endtask

	task automatic flag_field(string field, logic [31:0] want, logic [31:0] got);
		if (got !== want) begin
			err_count++;
			$display("%0t: %s mismatch, expected %h, actual %h", $time, field, want, got);
		end
	endtask

	// driver
	always @(negedge clk) begin
		table_cmd_t nxt;
		if (arst_n && (!req_ch.valid || req_fire)) begin
			if (cmd_backlog.size() != 0 && $urandom_range(99) >= idle_pct) begin
				nxt = cmd_backlog.pop_front();
				issued++;
				req_ch.valid <= 1'b1;
				req_ch.cmd <= nxt.cmd;
				req_ch.handle_in <= nxt.handle;
				req_ch.context_in <= nxt.ctx;
			end else begin
				req_ch.valid <= 1'b0;
			end
		end
	end

	always @(negedge clk) begin
		rsp_ch.ready <= ($urandom_range(99) >= stall_pct);
	end

	// monitor and checker
	always @(posedge clk) begin
		table_cmd_t seen_cmd;
		table_reply_t want;
		req_fire <= req_ch.valid && req_ch.ready;
		if (arst_n) begin
			if (cfg_we)
				node_cur = cfg_wdata;
			if (rsp_ch.valid && rsp_ch.ready) begin
				if (owed_replies.size() == 0) begin
					err_count++;
					$display("%0t: unexpected transfer, status %0d handle %h context %h",
						$time, rsp_ch.status, rsp_ch.handle_out, rsp_ch.context_out);
				end else begin
					want = owed_replies.pop_front();
					flag_field("status", 32'(want.status), 32'(rsp_ch.status));
					flag_field("handle_out", want.handle, rsp_ch.handle_out);
					flag_field("context_out", 32'(want.ctx), 32'(rsp_ch.context_out));
				end
			end
			if (req_ch.valid && req_ch.ready) begin
				seen_cmd.cmd = req_ch.cmd;
				seen_cmd.handle = req_ch.handle_in;
				seen_cmd.ctx = req_ch.context_in;
				owed_replies.push_back(serve_command(seen_cmd));
				taken++;
			end
		end
	end

	initial begin
		int ph;
		int n;
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_wdata = 8'h00;
		req_ch.valid = 1'b0;
		req_ch.cmd = hsta_pkg::CMD_REGISTER;
		req_ch.handle_in = '0;
		req_ch.context_in = '0;
		rsp_ch.ready = 1'b0;
		idle_pct = 0;
		stall_pct = 0;
		repeat (3) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;

		write_node(8'hFF);
		push_cmd(hsta_pkg::CMD_REGISTER, 32'hFFFF_FFFF, 16'h0000);
		push_cmd(hsta_pkg::CMD_REGISTER, 32'h0000_0000, 16'hFFFF);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFF00_0001, 16'h0000);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFF00_0002, 16'hFFFF);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'h0000_0002, 16'h0000);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFF00_0042, 16'h0000);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFE00_0002, 16'h0000);
		push_cmd(hsta_pkg::CMD_RETIRE,   32'hFF00_0001, 16'hFFFF);
		push_cmd(hsta_pkg::CMD_RETIRE,   32'hFF00_0001, 16'h0000);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFF00_0001, 16'h0000);
		push_cmd(CMD_UNUSED,             32'hFFFF_FFFF, 16'hFFFF);
		push_cmd(CMD_UNUSED,             32'h0000_0000, 16'h0000);
		push_cmd(hsta_pkg::CMD_REGISTER, 32'h1234_5678, 16'h1234);
		push_cmd(hsta_pkg::CMD_RETIRE,   32'hFF00_0002, 16'h0000);
		push_cmd(hsta_pkg::CMD_REGISTER, 32'h0000_0000, 16'h8001);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFF00_0004, 16'h0000);
		push_cmd(hsta_pkg::CMD_LOOKUP,   32'hFF00_0003, 16'h0000);
		wait_quiet();

		for (ph = 0; ph < PHASES; ph++) begin
			write_node(ph == 2 ? 8'($urandom) : ph_node[ph]);
			idle_pct = ph_idle[ph];
			stall_pct = ph_stall[ph];
			for (n = 0; n < ph_items[ph]; n++) begin
				while (cmd_backlog.size() != 0)
					@(negedge clk);
				cmd_backlog.push_back(make_item(ph_reg[ph], ph_ret[ph]));
			end
			wait_quiet();
		end

		repeat (2 * SLOTS + 4) @(negedge clk);
		$display("Covered %0d transfers in %0d traffic phases", taken, PHASES + 1);
		$display("  with node ids ff, 00, random, 80, 01.");
		$display("  %0d handles issued, %0d table-full refusals, %0d hits, %0d misses, %0d unused",
			n_alloc, n_full, n_hit, n_miss, n_unused);
		if (err_count == 0)
			$display("RESULT: OK");
		else
			$display("RESULT: ERROR");
		$finish;
	end

	initial begin
		#2000000;
		$display("RESULT: ERROR");
		$finish;
	end

endmodule

// ===== files.f =====
rtl/core/hsta_pkg.sv
rtl/core/hsta_ifs.sv
rtl/core/hsta_ctrl.sv
rtl/core/hsta_dp.sv
rtl/core/handle_slot_table_allocator.sv
dv/handle_slot_table_allocator_tb.sv
